// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int COPY_END   = (ROWS - 1) * COLUMNS;

	localparam int ADDR_W  = $clog2(CELL_COUNT);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLUMNS + 1);
	localparam int CELL_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int COLOUR_W = 4;
	localparam int COUNT_W = 32;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

	localparam logic ACTION_PUT  = 1'b0;
	localparam logic ACTION_READ = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd1;

	localparam logic [COLOUR_W-1:0] FOREGROUND_RESET = 4'hF;
	localparam logic [COLOUR_W-1:0] BACKGROUND_RESET = 4'h0;

	typedef struct packed {
		logic                 action;
		logic [CHAR_W-1:0]    char_code;
		logic [INDEX_W-1:0]   cell_index;
	} tcw_req_t;

	typedef struct packed {
		logic [CELL_W-1:0]  cell_word;
		logic [4:0]         cursor_row;
		logic [6:0]         cursor_column;
		logic [COUNT_W-1:0] chars_written;
	} tcw_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_step;
		logic capture;
		logic read_issue;
		logic read_take;
		logic line_advance;
		logic col_zero;
		logic count;
		logic sweep_step;
		logic put_write;
		logic rsp_load;
	} tcw_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic ptr_last;
		logic is_read;
		logic is_newline;
		logic col_full;
		logic row_bottom;
		logic rsp_free;
	} tcw_status_t;

endpackage

// ----- rtl/tcw_ram.sv -----
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/tcw_ctrl.sv -----
module tcw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  tcw_pkg::tcw_status_t st,
	output tcw_pkg::tcw_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_READ_WAIT,
		S_SCROLL,
		S_DRAIN,
		S_PUT,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (st.ptr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.is_read) begin
					cmd.read_issue = 1'b1;
					state_d        = S_READ_WAIT;
				end else if (st.is_newline) begin
					cmd.count = 1'b1;
					if (st.row_bottom) begin
						cmd.col_zero = 1'b1;
						state_d      = S_SCROLL;
					end else begin
						cmd.line_advance = 1'b1;
						state_d          = S_FINISH;
					end
				end else begin
					cmd.count = 1'b1;
					if (st.col_full && st.row_bottom) begin
						cmd.col_zero = 1'b1;
						state_d      = S_SCROLL;
					end else if (st.col_full) begin
						cmd.line_advance = 1'b1;
						state_d          = S_PUT;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_READ_WAIT: begin
				cmd.read_take = 1'b1;
				state_d       = S_FINISH;
			end
			S_SCROLL: begin
				cmd.sweep_step = 1'b1;
				if (st.ptr_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = st.is_newline ? S_FINISH : S_PUT;
			end
			S_PUT: begin
				cmd.put_write = 1'b1;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (st.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// A read never starts a scroll or a cell write
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && st.is_read) |-> !cmd.count && !cmd.col_zero && !cmd.line_advance)
		else $error("read item changed cursor state");

	// After a full sweep the drain cycle follows
	a_sweep_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCROLL && st.ptr_last) |=> state_q == S_DRAIN)
		else $error("scroll sweep did not drain");

endmodule

// ----- rtl/tcw_datapath.sv -----
module tcw_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tcw_pkg::tcw_cmd_t                    cmd,
	output tcw_pkg::tcw_status_t                 st,
	input  tcw_pkg::tcw_req_t                    req,
	input  logic                                 cfg_valid,
	input  logic [tcw_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [tcw_pkg::COLOUR_W-1:0]         cfg_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output tcw_pkg::tcw_rsp_t                    rsp
);

	tcw_pkg::tcw_req_t item_q;

	logic [tcw_pkg::ROW_W-1:0]    row_q;
	logic [tcw_pkg::COL_W-1:0]    col_q;
	logic [tcw_pkg::COUNT_W-1:0]  total_q;
	logic [tcw_pkg::COLOUR_W-1:0] fg_q;
	logic [tcw_pkg::COLOUR_W-1:0] bg_q;
	logic [tcw_pkg::ADDR_W-1:0]   ptr_q;
	logic [tcw_pkg::CELL_W-1:0]   word_q;

	logic                         valid_s1;
	logic [tcw_pkg::ADDR_W-1:0]   addr_s1;
	logic                         fill_s1;

	logic                         rsp_valid_q;
	tcw_pkg::tcw_rsp_t            rsp_q;

	logic                         in_range;
	logic                         ptr_copy;
	logic                         ptr_last;
	logic [tcw_pkg::ADDR_W-1:0]   put_addr;

	logic                         ram_we;
	logic [tcw_pkg::ADDR_W-1:0]   ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
	logic                         ram_re;
	logic [tcw_pkg::ADDR_W-1:0]   ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

	assign in_range = 32'(item_q.cell_index) < 32'(tcw_pkg::CELL_COUNT);
	assign ptr_copy = 32'(ptr_q) < 32'(tcw_pkg::COPY_END);
	assign ptr_last = ptr_q == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
	assign put_addr = tcw_pkg::ADDR_W'(32'(row_q) * tcw_pkg::COLUMNS + 32'(col_q));

	assign st.ptr_last   = ptr_last;
	assign st.is_read    = item_q.action == tcw_pkg::ACTION_READ;
	assign st.is_newline = item_q.char_code == tcw_pkg::NEWLINE_CODE;
	assign st.col_full   = 32'(col_q) == 32'(tcw_pkg::COLUMNS);
	assign st.row_bottom = 32'(row_q) == 32'(tcw_pkg::ROWS - 1);
	assign st.rsp_free   = !rsp_valid_q || rsp_ready;

	// Write port: clearing, scroll copy/fill stage, then a character put
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		if (cmd.clear_step) begin
			ram_we = 1'b1;
		end else if (valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = fill_s1 ? {bg_q, fg_q, tcw_pkg::CHAR_W'(0)} : ram_rdata;
		end else if (cmd.put_write) begin
			ram_we    = 1'b1;
			ram_waddr = put_addr;
			ram_wdata = {bg_q, fg_q, item_q.char_code};
		end
	end

	// Read port: cell read, or the row below during a scroll
	always_comb begin
		if (cmd.read_issue) begin
			ram_re    = in_range;
			ram_raddr = tcw_pkg::ADDR_W'(item_q.cell_index);
		end else begin
			ram_re    = cmd.sweep_step && ptr_copy;
			ram_raddr = tcw_pkg::ADDR_W'(32'(ptr_q) + tcw_pkg::COLUMNS);
		end
	end

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(tcw_pkg::CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			total_q     <= '0;
			fg_q        <= tcw_pkg::FOREGROUND_RESET;
			bg_q        <= tcw_pkg::BACKGROUND_RESET;
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					tcw_pkg::REG_FOREGROUND: fg_q <= cfg_data;
					tcw_pkg::REG_BACKGROUND: bg_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.line_advance) begin
				row_q <= row_q + 1'b1;
				col_q <= '0;
			end else if (cmd.col_zero) begin
				col_q <= '0;
			end else if (cmd.put_write) begin
				col_q <= col_q + 1'b1;
			end
			if (cmd.count) begin
				total_q <= total_q + 1'b1;
			end
			if (cmd.clear_step || cmd.sweep_step) begin
				ptr_q <= ptr_last ? '0 : ptr_q + 1'b1;
			end
			valid_s1 <= cmd.sweep_step;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
			word_q <= '0;
		end
		if (cmd.read_take) begin
			word_q <= in_range ? ram_rdata : '0;
		end
		addr_s1 <= ptr_q;
		fill_s1 <= !ptr_copy;
		if (cmd.rsp_load) begin
			rsp_q.cell_word     <= word_q;
			rsp_q.cursor_row    <= 5'(row_q);
			rsp_q.cursor_column <= 7'(col_q);
			rsp_q.chars_written <= total_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_step, valid_s1, cmd.put_write}))
		else $error("write port claimed twice");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) <= 32'(tcw_pkg::COLUMNS))
		else $error("column past line width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < 32'(tcw_pkg::ROWS))
		else $error("row past bottom");

	a_rsp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> !rsp_valid_q || rsp_ready)
		else $error("result overwritten before taken");

endmodule

// ----- rtl/text_console_writer_core.sv -----
// Character-cell console writer with a ROWS x COLUMNS grid of 16-bit cells
// (attribute high byte, character low byte) kept in one block RAM.
// req channel: action 0 puts char_code at the cursor (newline moves to the next
// row, scrolling at the bottom), action 1 reads the cell at cell_index.
// rsp channel: one transaction per request with the read cell (zero for a put),
// the cursor row and column after the request, and the running put count.
// cfg channel: index 0 foreground colour, index 1 background colour; always ready.
// Sequencing: a read or a character put passes through accept, decode, RAM access
// and result load before the next request is accepted; a newline that does not
// scroll skips the RAM access. A read result is registered from the RAM and then
// loaded into the result register. A scroll sweeps the RAM one cell per cycle
// through its single write port.
// Reset: cursor, count and colours return to their reset values, then a clearing
// pass writes zero to every cell, one per cycle; req_ready stays low during it,
// cfg writes are still taken.
// Receiver stall: the result register holds its transaction; the next request is
// still accepted and worked on, and its result waits until the register frees.
module text_console_writer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  tcw_pkg::tcw_req_t               req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output tcw_pkg::tcw_rsp_t               rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tcw_pkg::COLOUR_W-1:0]    cfg_data
);

	tcw_pkg::tcw_cmd_t    cmd;
	tcw_pkg::tcw_status_t st;

	// Colour writes go straight into their registers, so never back-pressure them
	assign cfg_ready = 1'b1;

	// Sequence each request: decode, wrap/scroll, RAM access, result load
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Hold cursor, count, colours, cell RAM and the result register
	tcw_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.req      (req),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
